// ----- rtl/clt_pkg.sv -----
// clt_pkg: request and result types, operation and status codes for the
// compacting list table. No dependencies; used by all modules but clt_ram.
`default_nettype none

package clt_pkg;

    // fixed field widths of the request and result
    localparam int unsigned OP_W      = 3;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned ST_W      = 2;
    localparam int unsigned CNT_OUT_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_VAL   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_IDX   = 3'd2;
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd3;
    localparam logic [OP_W-1:0] OP_REVERSE   = 3'd4;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         req_type;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [IDX_W-1:0]     found_index;
        logic [CNT_OUT_W-1:0] count;
    } t_res;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic rev_rd_lo;
        logic rev_rd_hi;
        logic rev_wr_lo;
        logic rev_wr_hi;
        logic finish;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic rev_more;
        logic cnt_gt1;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/clt_ram.sv -----
// clt_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
`default_nettype none

module clt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/clt_ctrl.sv -----
// clt_ctrl: controller state machine of the compacting list table.
// Depends on clt_pkg for states, commands and operation codes.
`default_nettype none

module clt_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [clt_pkg::OP_W-1:0] i_op,
    input  wire clt_pkg::t_sts          i_sts,
    output clt_pkg::t_cmd               o_cmd,
    output logic                        o_busy
);

    import clt_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_op) inside
                        OP_DEL_VAL, OP_DEL_IDX, OP_SEARCH: n_state = S_SCAN;
                        OP_REVERSE: begin
                            n_state = i_sts.cnt_gt1 ? S_REV_RD_LO : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_REV_RD_LO: n_state = S_REV_RD_HI;
            S_REV_RD_HI: n_state = S_REV_WR_LO;
            S_REV_WR_LO: n_state = S_REV_WR_HI;
            S_REV_WR_HI: n_state = i_sts.rev_more ? S_REV_RD_LO : S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_SCAN:      o_cmd.scan      = 1'b1;
            S_REV_RD_LO: o_cmd.rev_rd_lo = 1'b1;
            S_REV_RD_HI: o_cmd.rev_rd_hi = 1'b1;
            S_REV_WR_LO: o_cmd.rev_wr_lo = 1'b1;
            S_REV_WR_HI: o_cmd.rev_wr_hi = 1'b1;
            S_DONE:      o_cmd.finish    = 1'b1;
            default:     o_busy          = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/clt_dpath.sv -----
// clt_dpath: datapath of the compacting list table: entry RAM, fill count,
// scan and swap pointers, result register. Depends on clt_pkg and clt_ram.
`default_nettype none

module clt_dpath #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire clt_pkg::t_req i_req,
    input  wire clt_pkg::t_cmd i_cmd,
    output clt_pkg::t_sts      o_sts,
    output clt_pkg::t_res      o_res,
    output logic               o_done
);

    import clt_pkg::*;

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam int unsigned OW   = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_req             r_req;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic [CW-1:0]    r_ptr;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_pos;
    logic             r_hit;
    logic [AW-1:0]    r_where;
    logic [AW-1:0]    r_lo;
    logic [AW-1:0]    r_hi;
    logic [VAL_W-1:0] r_tmp;
    t_res             r_res;
    t_res             n_res;
    logic             r_done;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] rd_data;

    logic             issue;
    logic             is_delete;
    logic             val_match;
    logic             pos_match;
    logic             match;
    logic [CMPW-1:0]  idx_ext;
    logic             idx_ok;
    logic [AW-1:0]    idx_a;
    logic [CW-1:0]    cnt_m1;
    logic [AW-1:0]    fin_where;
    logic [CMPW-1:0]  where_ext;
    logic [OW-1:0]    cnt_ext;
    logic             fin_ok;

    // entry store
    clt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // request decode and compares
    assign idx_ext   = CMPW'(r_req.index);
    assign idx_ok    = idx_ext < CMPW'(r_cnt);
    assign idx_a     = idx_ext[AW-1:0];
    assign cnt_m1    = r_cnt - CW'(1);
    assign issue     = i_cmd.scan && (r_ptr < r_cnt);
    assign is_delete = (r_req.req_type == OP_DEL_VAL) || (r_req.req_type == OP_DEL_IDX);
    assign val_match = rd_data == $unsigned(r_req.value);
    assign pos_match = CMPW'(r_rd_pos) == idx_ext;
    assign match     = (r_req.req_type == OP_DEL_IDX) ? pos_match : val_match;

    // status to controller
    assign o_sts.scan_done = !(r_ptr < r_cnt) && !r_rd_vld;
    assign o_sts.rev_more  = ({1'b0, r_lo} + (AW + 1)'(2)) < {1'b0, r_hi};
    assign o_sts.cnt_gt1   = r_cnt > CW'(1);

    // read address select
    always_comb begin
        if (i_cmd.rev_rd_lo) begin
            ram_raddr = r_lo;
        end else if (i_cmd.rev_rd_hi) begin
            ram_raddr = r_hi;
        end else begin
            ram_raddr = r_ptr[AW-1:0];
        end
    end

    // write port: gap closing, swaps, overwrite and append
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = rd_data;
        if (i_cmd.scan && r_rd_vld && r_hit && is_delete) begin
            ram_we    = 1'b1;
            ram_waddr = r_rd_pos - AW'(1);
        end else if (i_cmd.rev_wr_lo) begin
            ram_we    = 1'b1;
            ram_waddr = r_lo;
        end else if (i_cmd.rev_wr_hi) begin
            ram_we    = 1'b1;
            ram_waddr = r_hi;
            ram_wdata = r_tmp;
        end else if (i_cmd.finish) begin
            if (r_req.req_type == OP_OVERWRITE && idx_ok) begin
                ram_we    = 1'b1;
                ram_waddr = idx_a;
                ram_wdata = r_req.value;
            end else if (r_req.req_type == OP_APPEND && r_cnt < CAP_C) begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = r_req.value;
            end
        end
    end

    // final result and new count
    always_comb begin
        n_cnt         = r_cnt;
        n_res.status  = ST_OK;
        fin_where     = '0;
        case (r_req.req_type)
            OP_OVERWRITE: begin
                if (idx_ok) begin
                    fin_where = idx_a;
                end else begin
                    n_res.status = ST_RANGE;
                end
            end
            OP_DEL_VAL, OP_DEL_IDX: begin
                if (r_hit) begin
                    fin_where = r_where;
                    n_cnt     = cnt_m1;
                end else if (r_req.req_type == OP_DEL_VAL) begin
                    n_res.status = ST_NOTFOUND;
                end else begin
                    n_res.status = ST_RANGE;
                end
            end
            OP_APPEND: begin
                if (r_cnt < CAP_C) begin
                    fin_where = r_cnt[AW-1:0];
                    n_cnt     = r_cnt + CW'(1);
                end else begin
                    n_res.status = ST_FULL;
                end
            end
            OP_SEARCH: begin
                if (r_hit) begin
                    fin_where = r_where;
                end else begin
                    n_res.status = ST_NOTFOUND;
                end
            end
            default: begin
            end
        endcase
        fin_ok            = n_res.status == ST_OK;
        where_ext         = fin_ok ? CMPW'(fin_where) : '0;
        cnt_ext           = OW'(n_cnt);
        n_res.found_index = where_ext[IDX_W-1:0];
        n_res.count       = cnt_ext[CNT_OUT_W-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            r_done   <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_cnt <= n_cnt;
            end
        end
    end

    // request, pointers and match tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req;
            r_ptr   <= '0;
            r_hit   <= 1'b0;
            r_where <= '0;
            r_lo    <= '0;
            r_hi    <= cnt_m1[AW-1:0];
        end else begin
            if (issue) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (i_cmd.scan && r_rd_vld) begin
                if (r_req.req_type == OP_SEARCH && val_match) begin
                    r_hit   <= 1'b1;
                    r_where <= r_rd_pos;
                end else if (is_delete && !r_hit && match) begin
                    r_hit   <= 1'b1;
                    r_where <= r_rd_pos;
                end
            end
            if (i_cmd.rev_wr_hi) begin
                r_lo <= r_lo + AW'(1);
                r_hi <= r_hi - AW'(1);
            end
        end
        r_rd_pos <= r_ptr[AW-1:0];
        if (i_cmd.rev_rd_hi) begin
            r_tmp <= rd_data;
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- rtl/compacting_list_table.sv -----
// compacting_list_table: dense list of 32-bit words with a fill count.
// Depends on clt_pkg, clt_ctrl, clt_dpath (which holds clt_ram).
//
// Usage: a request (operation, index, value) is taken on i_req at a rising
// edge where start is high and busy is low. Each request gives exactly one
// result on o_res, shown for a single cycle with o_done high; the receiver
// cannot hold it off. Requests: overwrite, delete by value, delete by index,
// append, reverse, search. Each result carries a status, the index removed or
// found and the fill count after the operation.
// Steps from acceptance to the o_done cycle, with n the fill count:
//   overwrite, append, unused codes: no scan and no swap
//   delete by value/index, search:   a scan of all n entries (none if empty),
//                                    one RAM read per entry
//   reverse:                         floor(n/2) swaps of low and high entry
// The entry RAM has one read and one write port; the scans and the swaps
// go through that read port. busy stays high from the cycle
// after acceptance until the result is registered.
// Reset empties the list (fill count zero); entry contents are not cleared
// and no clearing pass runs, the fill count marks what is valid.
`default_nettype none

module compacting_list_table #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire clt_pkg::t_req i_req,
    output logic               busy,
    output logic               o_done,
    output clt_pkg::t_res      o_res
);

    import clt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller
    clt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_req.req_type),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath
    clt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_res),
        .o_done  (o_done)
    );

    // a result only appears once the request has left the controller
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // one request gives one strobe, never two in a row
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe repeated");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // failed requests report index zero
    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ST_OK) |-> (o_res.found_index == '0))
        else $error("nonzero index with failing status");

endmodule

`default_nettype wire

// ----- tb/list_table_checker.sv -----
// list_table_checker: watches the request and result channels of the compacting
// list table, predicts each result from its own copy of the list and compares.
// Depends on clt_pkg for the request and result types and the codes.
`timescale 1ns / 100ps

module list_table_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  clt_pkg::t_req i_req,
    input  logic          i_done,
    input  clt_pkg::t_res i_res,
    output int unsigned   o_errors,
    output int unsigned   o_pending,
    output int unsigned   o_checked,
    output logic [6:0]    o_fill
);

    import clt_pkg::*;

    // shadow copy of the list
    logic [VAL_W-1:0] words [CAPACITY];
    int unsigned      fill;

    // results predicted but not yet seen
    t_res        awaited_results[$];
    t_res        oldest;
    int unsigned errors;
    int unsigned checked;

    assign o_errors  = errors;
    assign o_checked = checked;

    // remove one entry and close the gap
    function automatic void close_gap(input int unsigned pos);
        int unsigned k;
        for (k = pos; k + 1 < fill; k++) begin
            words[k] = words[k + 1];
        end
        fill--;
    endfunction

    // apply one request to the shadow list and return the result it gives
    function automatic t_res apply_request(input t_req r);
        t_res        res;
        logic [1:0]  st;
        int unsigned where;
        int unsigned k;
        int unsigned lo;
        int unsigned hi;
        bit          hit;
        logic [31:0] tmp;
        st    = ST_OK;
        where = 0;
        hit   = 1'b0;
        case (r.req_type)
            OP_OVERWRITE: begin
                if (r.index < fill) begin
                    words[r.index] = r.value;
                    where = r.index;
                end else begin
                    st = ST_RANGE;
                end
            end
            OP_DEL_VAL: begin
                // first match wins
                for (k = 0; k < fill && !hit; k++) begin
                    if (words[k] == r.value) begin
                        hit   = 1'b1;
                        where = k;
                    end
                end
                if (hit) begin
                    close_gap(where);
                end else begin
                    st = ST_NOTFOUND;
                end
            end
            OP_DEL_IDX: begin
                if (r.index < fill) begin
                    close_gap(r.index);
                    where = r.index;
                end else begin
                    st = ST_RANGE;
                end
            end
            OP_APPEND: begin
                if (fill < CAPACITY) begin
                    words[fill] = r.value;
                    where = fill;
                    fill++;
                end else begin
                    st = ST_FULL;
                end
            end
            OP_REVERSE: begin
                if (fill > 1) begin
                    lo = 0;
                    hi = fill - 1;
                    while (lo < hi) begin
                        tmp       = words[lo];
                        words[lo] = words[hi];
                        words[hi] = tmp;
                        lo++;
                        hi--;
                    end
                end
            end
            OP_SEARCH: begin
                // last match wins
                for (k = 0; k < fill; k++) begin
                    if (words[k] == r.value) begin
                        hit   = 1'b1;
                        where = k;
                    end
                end
                if (!hit) begin
                    st = ST_NOTFOUND;
                end
            end
            default: begin
            end
        endcase
        res.status      = st;
        res.found_index = (st == ST_OK) ? where[IDX_W-1:0] : '0;
        res.count       = fill[CNT_OUT_W-1:0];
        return res;
    endfunction

    // count a failure, describe only the first few
    task automatic note_failure(input string what, input t_res exp_res,
                                input t_res act_res);
        errors++;
        if (errors <= 10) begin
            $display("[%0t] %s: expected status %0d index %0d count %0d,",
                     $realtime, what, exp_res.status, exp_res.found_index,
                     exp_res.count);
            $display("    got status %0d index %0d count %0d",
                     act_res.status, act_res.found_index, act_res.count);
        end
    endtask

    // compare finished results first, then predict the newly taken request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill = 0;
            awaited_results.delete();
            errors    = 0;
            checked   = 0;
            o_pending <= 0;
            o_fill    <= '0;
        end else begin
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    note_failure("result with no request outstanding", '0, i_res);
                end else begin
                    oldest = awaited_results.pop_front();
                    checked++;
                    if (oldest.status !== i_res.status
                            || oldest.found_index !== i_res.found_index
                            || oldest.count !== i_res.count) begin
                        note_failure("result mismatch", oldest, i_res);
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_results.push_back(apply_request(i_req));
            end
            o_pending <= awaited_results.size();
            o_fill    <= fill[6:0];
        end
    end

endmodule

// ----- tb/testbench.sv -----
// testbench: drives directed and random requests into compacting_list_table
// and gives the verdict from the failure count of list_table_checker.
// Depends on clt_pkg, the block and tb/list_table_checker.sv.
`timescale 1ns / 100ps

module testbench;
    import clt_pkg::*;

    localparam int unsigned CAPACITY   = 64;
    localparam int unsigned ITEM_GOAL  = 1500;
    localparam int unsigned IDLE_LIMIT = 4000;

    // request codes with no operation behind them
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_MIXED,
        MODE_DRAIN
    } t_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_req        req;
    logic        busy;
    logic        done;
    t_res        res;

    int unsigned errors;
    int unsigned pending;
    int unsigned checked;
    logic [6:0]  fill_seen;

    int unsigned sent;
    int unsigned op_sent [8];
    int unsigned peak_fill;
    int unsigned idle_cycles;
    logic [31:0] value_pool [8];

    compacting_list_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (req),
        .busy   (busy),
        .o_done (done),
        .o_res  (res)
    );

    list_table_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_req    (req),
        .i_done   (done),
        .i_res    (res),
        .o_errors (errors),
        .o_pending(pending),
        .o_checked(checked),
        .o_fill   (fill_seen)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog: too long with no request taken and no result given
    always @(posedge i_clk) begin
        if ((start && !busy) || done || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("compacting_list_table regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one request after a gap and wait until it is taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] val, input int unsigned gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        req   <= '{req_type: op, index: idx, value: val};
        do begin
            @(posedge i_clk);
        end while (busy);
        sent++;
        op_sent[op]++;
        if (fill_seen > peak_fill) begin
            peak_fill = fill_seen;
        end
    endtask

    // hold requests back until every result has come
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // weighted choice of operation for the current mode
    function automatic logic [OP_W-1:0] pick_op(input t_mode mode);
        int unsigned r;
        int unsigned t_app;
        int unsigned t_ovw;
        int unsigned t_srch;
        int unsigned t_dval;
        int unsigned t_didx;
        int unsigned t_rev;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                t_app = 70; t_ovw = 76; t_srch = 82; t_dval = 87; t_didx = 92; t_rev = 97;
            end
            MODE_DRAIN: begin
                t_app = 10; t_ovw = 20; t_srch = 30; t_dval = 55; t_didx = 85; t_rev = 95;
            end
            default: begin
                t_app = 25; t_ovw = 40; t_srch = 55; t_dval = 67; t_didx = 79; t_rev = 94;
            end
        endcase
        if (r < t_app)  return OP_APPEND;
        if (r < t_ovw)  return OP_OVERWRITE;
        if (r < t_srch) return OP_SEARCH;
        if (r < t_dval) return OP_DEL_VAL;
        if (r < t_didx) return OP_DEL_IDX;
        if (r < t_rev)  return OP_REVERSE;
        return ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
    endfunction

    // mostly positions inside the list, sometimes anywhere
    function automatic logic [IDX_W-1:0] pick_index();
        if (fill_seen > 0 && $urandom_range(0, 9) < 8) begin
            return IDX_W'($urandom_range(0, fill_seen - 1));
        end
        return IDX_W'($urandom_range(0, 63));
    endfunction

    // mostly words from a small pool so that searches and deletes hit
    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom();
    endfunction

    // stimulus and verdict
    initial begin
        int unsigned phase_len;
        int unsigned k;
        int unsigned phase_no;
        bit          no_gaps;
        t_mode       mode;

        start       = 1'b0;
        req         = '0;
        i_rst_n     = 1'b0;
        sent        = 0;
        peak_fill   = 0;
        for (k = 0; k < 8; k++) begin
            op_sent[k] = 0;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extremes of the word, first and last match
        send_request(OP_REVERSE,   6'd0,  32'h0000_0000, 0);
        send_request(OP_SEARCH,    6'd0,  32'h0000_0000, 1);
        send_request(OP_DEL_VAL,   6'd0,  32'h0000_0000, 0);
        send_request(OP_DEL_IDX,   6'd0,  32'h0000_0000, 2);
        send_request(OP_OVERWRITE, 6'd0,  32'hFFFF_FFFF, 0);
        send_request(OP_SPARE_6,   6'd0,  32'h0000_0000, 3);
        send_request(OP_SPARE_7,   6'd63, 32'hFFFF_FFFF, 0);
        send_request(OP_APPEND,    6'd63, 32'h8000_0000, 0);
        send_request(OP_REVERSE,   6'd0,  32'h0000_0000, 1);
        send_request(OP_APPEND,    6'd0,  32'h7FFF_FFFF, 0);
        send_request(OP_APPEND,    6'd0,  32'hFFFF_FFFF, 0);
        send_request(OP_APPEND,    6'd0,  32'h8000_0000, 2);
        send_request(OP_SEARCH,    6'd0,  32'h8000_0000, 0);
        send_request(OP_DEL_VAL,   6'd0,  32'h8000_0000, 0);
        send_request(OP_OVERWRITE, 6'd2,  32'h0000_0000, 1);
        send_request(OP_OVERWRITE, 6'd3,  32'h5555_AAAA, 0);
        send_request(OP_REVERSE,   6'd0,  32'h0000_0000, 0);
        send_request(OP_DEL_IDX,   6'd63, 32'h0000_0000, 3);
        send_request(OP_SEARCH,    6'd0,  32'h1234_5678, 0);
        send_request(OP_DEL_IDX,   6'd2,  32'h0000_0000, 0);
        send_request(OP_DEL_IDX,   6'd0,  32'h0000_0000, 1);
        send_request(OP_OVERWRITE, 6'd63, 32'hAAAA_5555, 0);
        drain_results();

        // random phases: fill towards full, mixed traffic, drain towards empty
        phase_no = 0;
        while (sent < ITEM_GOAL) begin
            case (phase_no % 4)
                0:       mode = MODE_FILL;
                2:       mode = MODE_DRAIN;
                default: mode = MODE_MIXED;
            endcase
            phase_len = (mode == MODE_FILL) ? $urandom_range(120, 200)
                                            : $urandom_range(60, 160);
            no_gaps   = ($urandom_range(0, 2) == 0);
            for (k = 0; k < 8; k++) begin
                case ($urandom_range(0, 7))
                    0:       value_pool[k] = 32'h8000_0000;
                    1:       value_pool[k] = 32'h7FFF_FFFF;
                    2:       value_pool[k] = 32'hFFFF_FFFF;
                    3:       value_pool[k] = 32'h0000_0000;
                    default: value_pool[k] = $urandom();
                endcase
            end
            for (k = 0; k < phase_len; k++) begin
                send_request(pick_op(mode), pick_index(), pick_value(),
                             no_gaps ? 0 : $urandom_range(0, 3));
            end
            drain_results();
            phase_no++;
        end

        // settle: nothing left in flight, then a tail longer than any operation
        drain_results();
        repeat (200) @(negedge i_clk);

        $display("%0d requests: overwrite %0d, delete by value %0d,",
                 sent, op_sent[OP_OVERWRITE], op_sent[OP_DEL_VAL]);
        $display("delete by index %0d, append %0d, reverse %0d, search %0d, spare codes %0d;",
                 op_sent[OP_DEL_IDX], op_sent[OP_APPEND], op_sent[OP_REVERSE],
                 op_sent[OP_SEARCH], op_sent[OP_SPARE_6] + op_sent[OP_SPARE_7]);
        $display("%0d results checked, peak fill %0d", checked, peak_fill);
        if (errors == 0) begin
            $display("compacting_list_table regression: pass");
        end else begin
            $display("%0d failures", errors);
            $display("compacting_list_table regression: fail");
        end
        $finish;
    end

endmodule
